// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared definitions of the peak-to-peak amplitude smoother
// Widths, weight constants, the queue status group and the back-end states.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS       = 16;
  localparam int WEIGHT_BITS     = 17;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 17'd6554;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_WRITE
  } back_state_t;

endpackage

// ===== src/peak_to_peak_amplitude_smoother.sv =====
// ----------------------------------------------------------------------------
// peak_to_peak_amplitude_smoother: block peak-to-peak with smoothing
// Tracks the extremes of each sample block and reports the block's
// peak-to-peak value with an exponentially smoothed amplitude.
//
//  channel  direction  handshake                 contents
//  s_*      in         s_tvalid / s_tready       sample, block_end on s_tlast
//  m_*      out        m_tvalid / m_tready       peak_to_peak, smoothed_amplitude
//  cfg_*    in         cfg_valid / cfg_ready     smoothing_weight
//
// One sample is taken per cycle. Each finished block passes through the
// smoother's three steps (queue read and difference, multiply, update); a
// four-entry queue absorbs runs of short blocks, and s_tready drops only
// while it is full. Reset clears the block tracker, the queue, the smoothed
// value and the output valid flag, and loads the weight with its default.
// ----------------------------------------------------------------------------
module peak_to_peak_amplitude_smoother #(
  parameter int SAMPLE_BITS = pps_pkg::SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // sample in the low SAMPLE_BITS bits, zero padding above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // peak_to_peak, then smoothed_amplitude, zero padding above
  output logic [((2*SAMPLE_BITS+pps_pkg::FRAC_BITS+7)/8)*8-1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pps_pkg::WEIGHT_BITS-1:0] cfg_data
);
  import pps_pkg::*;

  localparam int OUT_BITS = ((2*SAMPLE_BITS+FRAC_BITS+7)/8)*8;

  queue_status_t                      queue_status;
  logic                               push;
  logic [SAMPLE_BITS-1:0]             push_data;
  logic                               pop;
  logic [SAMPLE_BITS-1:0]             pop_data;
  logic [SAMPLE_BITS-1:0]             out_p2p;
  logic [SAMPLE_BITS+FRAC_BITS-1:0]   out_smoothed;

  pps_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample       (s_tdata[SAMPLE_BITS-1:0]),
    .block_end    (s_tlast),
    .queue_status (queue_status),
    .push         (push),
    .push_data    (push_data)
  );

  pps_queue #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .DEPTH      (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (queue_status)
  );

  pps_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .queue_status (queue_status),
    .pop_data     (pop_data),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_p2p      (out_p2p),
    .out_smoothed (out_smoothed)
  );

  assign m_tdata = OUT_BITS'({out_smoothed, out_p2p});

endmodule

// ===== src/pps_front.sv =====
// ----------------------------------------------------------------------------
// pps_front: block extreme tracker
// Accepts samples, keeps the running maximum and minimum of the open block,
// and hands the peak-to-peak value of each finished block to the queue.
// ----------------------------------------------------------------------------
module pps_front #(
  parameter int SAMPLE_BITS = pps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   block_end,
  input  pps_pkg::queue_status_t queue_status,
  output logic                   push,
  output logic [SAMPLE_BITS-1:0] push_data
);
  import pps_pkg::*;

  logic [SAMPLE_BITS-1:0] block_max;
  logic [SAMPLE_BITS-1:0] block_min;
  logic                   block_start;
  logic [SAMPLE_BITS-1:0] block_max_next;
  logic [SAMPLE_BITS-1:0] block_min_next;
  logic                   accept;

  assign in_ready = !queue_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (block_start) begin
      block_max_next = sample;
      block_min_next = sample;
    end else begin
      block_max_next = (sample > block_max) ? sample : block_max;
      block_min_next = (sample < block_min) ? sample : block_min;
    end
  end

  assign push      = accept && block_end;
  assign push_data = block_max_next - block_min_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_max   <= '0;
      block_min   <= '0;
      block_start <= 1'b1;
    end else if (accept) begin
      block_max   <= block_max_next;
      block_min   <= block_min_next;
      block_start <= block_end;
    end
  end

endmodule

// ===== src/pps_queue.sv =====
// ----------------------------------------------------------------------------
// pps_queue: peak-to-peak queue
// Short first-in first-out store between the tracker and the smoother.
// ----------------------------------------------------------------------------
module pps_queue #(
  parameter int SAMPLE_BITS = pps_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH       = pps_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [SAMPLE_BITS-1:0] push_data,
  input  logic                   pop,
  output logic [SAMPLE_BITS-1:0] pop_data,
  output pps_pkg::queue_status_t status
);
  import pps_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [SAMPLE_BITS-1:0] entries [DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr;
  logic [PTR_BITS-1:0]    rd_ptr;
  logic [CNT_BITS-1:0]    count;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_BITS'(DEPTH));
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a lone write");
`endif

endmodule

// ===== src/pps_back.sv =====
// ----------------------------------------------------------------------------
// pps_back: exponential smoother
// Takes peak-to-peak values from the queue, updates the smoothed amplitude
// as prev + ((w * ((p2p << 16) - prev)) >>> 16) and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module pps_back #(
  parameter int SAMPLE_BITS = pps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pps_pkg::WEIGHT_BITS-1:0]        cfg_data,
  input  pps_pkg::queue_status_t                 queue_status,
  input  logic [SAMPLE_BITS-1:0]                 pop_data,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [SAMPLE_BITS-1:0]                 out_p2p,
  output logic [SAMPLE_BITS+pps_pkg::FRAC_BITS-1:0] out_smoothed
);
  import pps_pkg::*;

  localparam int SMOOTH_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int DIFF_BITS   = SMOOTH_BITS + 1;
  localparam int PROD_BITS   = DIFF_BITS + WEIGHT_BITS + 1;

  back_state_t state;
  back_state_t state_next;

  logic [WEIGHT_BITS-1:0]      weight;
  logic [SMOOTH_BITS-1:0]      smoothed_value;
  logic [SMOOTH_BITS-1:0]      smoothed_value_next;
  logic [SAMPLE_BITS-1:0]      p2p;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [DIFF_BITS-1:0] diff_next;
  logic signed [PROD_BITS-1:0] product;
  logic signed [PROD_BITS-1:0] product_shift;
  logic                        write;

  assign cfg_ready = 1'b1;

  // Weights above one are stored as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
    end else if (cfg_valid) begin
      weight <= (cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!queue_status.empty) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    write = 1'b0;
    unique case (state)
      S_IDLE:  pop   = !queue_status.empty;
      S_MUL:   write = 1'b0;
      S_WRITE: write = !out_valid || out_ready;
      default: begin
        pop   = 1'b0;
        write = 1'b0;
      end
    endcase
  end

  assign diff_next = signed'({1'b0, pop_data, FRAC_BITS'(0)})
                   - signed'({1'b0, smoothed_value});
  assign product_shift       = product >>> FRAC_BITS;
  // The true result lies in range, so the low bits of the sum are exact.
  assign smoothed_value_next = smoothed_value + product_shift[SMOOTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      diff <= diff_next;
      p2p  <= pop_data;
    end
    if (state == S_MUL) begin
      product <= diff * signed'({1'b0, weight});
    end
    if (write) begin
      out_p2p      <= p2p;
      out_smoothed <= smoothed_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      smoothed_value <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (write) begin
        smoothed_value <= smoothed_value_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_IDLE))
    else $error("queue read outside the idle state");
  a_pop_mul: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_MUL))
    else $error("multiply step did not follow a queue read");
  a_write_shows: assert property (@(posedge clk) disable iff (rst)
    write |=> (out_valid && out_smoothed == smoothed_value))
    else $error("result register and smoothed state disagree");
`endif

endmodule

// ===== dv/p2p_smoothing_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2p_smoothing_checker: result checker for the amplitude smoother
// Watches the sample, weight and result channels, predicts each block's
// peak-to-peak value and smoothed amplitude, and compares every result.
// ----------------------------------------------------------------------------
module p2p_smoothing_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // sample, zero padding above
  input  logic [((pps_pkg::SAMPLE_BITS_DEF+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,
  input  logic m_tvalid,
  input  logic m_tready,
  // peak_to_peak, then smoothed_amplitude, zero padding above
  input  logic [((2*pps_pkg::SAMPLE_BITS_DEF+pps_pkg::FRAC_BITS+7)/8)*8-1:0] m_tdata,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [pps_pkg::WEIGHT_BITS-1:0] cfg_data,
  output int   mismatches,
  output int   outstanding_blocks
);
  import pps_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int SMOOTH_BITS = SB + FRAC_BITS;

  typedef struct packed {
    logic [SB-1:0]          p2p;
    logic [SMOOTH_BITS-1:0] amplitude;
  } block_result_t;

  block_result_t          expected_blocks[$];
  logic [WEIGHT_BITS-1:0] weight;
  logic [SB-1:0]          run_max;
  logic [SB-1:0]          run_min;
  logic                   block_open;
  logic [SMOOTH_BITS-1:0] smoothed;

  always @(posedge clk) begin : watch
    logic [SB-1:0]          s;
    logic [SB-1:0]          got_p2p;
    logic [SMOOTH_BITS-1:0] got_amp;
    logic [63:0]            w;
    logic [63:0]            acc;
    block_result_t          res;
    if (rst) begin
      weight     = WEIGHT_RESET;
      run_max    = '0;
      run_min    = '0;
      block_open = 1'b0;
      smoothed   = '0;
      expected_blocks.delete();
    end else begin
      // Results are checked before this edge's sample is taken in, since a
      // result can never belong to the request accepted at the same edge.
      if (m_tvalid && m_tready) begin
        got_p2p = m_tdata[SB-1:0];
        got_amp = m_tdata[SB +: SMOOTH_BITS];
        if (expected_blocks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, peak_to_peak %0d smoothed_amplitude %0d",
                   $time, got_p2p, got_amp);
        end else begin
          res = expected_blocks.pop_front();
          if (got_p2p !== res.p2p) begin
            mismatches++;
            $display("%0t: peak_to_peak mismatch, expected %0d, got %0d",
                     $time, res.p2p, got_p2p);
          end
          if (got_amp !== res.amplitude) begin
            mismatches++;
            $display("%0t: smoothed_amplitude mismatch, expected %0d, got %0d",
                     $time, res.amplitude, got_amp);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        weight = cfg_data;
      if (s_tvalid && s_tready) begin
        s = s_tdata[SB-1:0];
        if (!block_open) begin
          run_max = s;
          run_min = s;
        end else begin
          if (s > run_max) run_max = s;
          if (s < run_min) run_min = s;
        end
        block_open = !s_tlast;
        if (s_tlast) begin
          // Weights above one saturate to one.
          w   = (weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(weight);
          acc = w * (64'(run_max - run_min) << FRAC_BITS)
                + (64'(WEIGHT_ONE) - w) * 64'(smoothed);
          smoothed      = acc[FRAC_BITS +: SMOOTH_BITS];
          res.p2p       = run_max - run_min;
          res.amplitude = smoothed;
          expected_blocks.push_back(res);
        end
      end
    end
    outstanding_blocks = expected_blocks.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the peak-to-peak amplitude smoother
// Sends directed and random sample blocks under several smoothing weights,
// with random idling on both sides, a long result hold-off that fills the
// block queue, and full drains between weight changes.
// ----------------------------------------------------------------------------
module testbench;
  import pps_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int S_W           = ((SB+7)/8)*8;
  localparam int M_W           = ((2*SB+FRAC_BITS+7)/8)*8;
  localparam int IDLE_PCT      = 13;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;
  localparam logic [SB-1:0] SAMPLE_MAX = '1;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_W-1:0]         s_tdata   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_W-1:0]         m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [WEIGHT_BITS-1:0] cfg_data  = '0;
  int                     mismatches;
  int                     outstanding_blocks;
  bit                     tx_calm   = 1'b0;
  bit                     rx_calm   = 1'b0;
  bit                     hold_req  = 1'b0;

  always #4 clk = ~clk;

  peak_to_peak_amplitude_smoother u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  p2p_smoothing_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .s_tlast            (s_tlast),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .outstanding_blocks (outstanding_blocks)
  );

  task automatic send_sample(input logic [S_W-1:0] word, input logic last);
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [S_W-1:0] random_word();
    logic [SB-1:0]  s;
    logic [S_W-1:0] word;
    case ($urandom_range(9)) inside
      0:       s = '0;
      1:       s = SAMPLE_MAX;
      [2:3]:   s = SB'($urandom_range(2100, 2000));
      default: s = SB'($urandom);
    endcase
    word         = '0;
    word[SB-1:0] = s;
    // Now and then the padding bits carry junk, which must be ignored.
    if ($urandom_range(7) == 0)
      word[S_W-1:SB] = (S_W-SB)'($urandom);
    return word;
  endfunction

  task automatic send_random_blocks(input int count);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 50)
        len = $urandom_range(3, 1);
      else if (r < 85)
        len = $urandom_range(10, 4);
      else
        len = $urandom_range(40, 11);
      for (int i = 0; i < len; i++)
        send_sample(random_word(), i == len - 1);
      sent += len;
    end
  endtask

  task automatic write_weight(input logic [WEIGHT_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The first edge lets the checker record the last request before the
  // outstanding count is looked at.
  task automatic drain(input int extra);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding_blocks == 0);
    repeat (extra) @(posedge clk);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed blocks under the default weight.
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0FFF, 1'b1);
    send_sample(16'h0FFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0FFF, 1'b1);
    send_sample(16'h0800, 1'b0);
    send_sample(16'h0FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0555, 1'b1);
    send_sample(16'h0AAA, 1'b0);
    send_sample(16'h0555, 1'b1);
    // Junk in the padding bits.
    send_sample(16'hF001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h1000, 1'b1);
    send_sample(16'h0064, 1'b0);
    send_sample(16'h00C8, 1'b0);
    send_sample(16'h012C, 1'b0);
    send_sample(16'h0032, 1'b1);
    send_sample(16'h0007, 1'b0);
    send_sample(16'h0007, 1'b0);
    send_sample(16'h0007, 1'b1);
    drain(SETTLE_CYCLES);

    // No smoothing, and no idling on either side.
    write_weight(WEIGHT_ONE);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_random_blocks(70);
    drain(SETTLE_CYCLES);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Zero weight freezes the smoothed value.
    write_weight('0);
    send_random_blocks(50);
    drain(SETTLE_CYCLES);

    // Saturating weight while results are held off and single-sample blocks
    // keep coming, so the queue fills and the input stalls.
    write_weight('1);
    tx_calm  = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_sample(random_word(), 1'b1);
    tx_calm = 1'b0;
    drain(SETTLE_CYCLES);

    write_weight(17'd1);
    send_random_blocks(60);
    drain(SETTLE_CYCLES);

    write_weight(WEIGHT_ONE - 17'd1);
    send_random_blocks(60);
    drain(SETTLE_CYCLES);

    repeat (4) begin
      if ($urandom_range(3) == 0)
        write_weight(WEIGHT_BITS'($urandom_range(131071, 65537)));
      else
        write_weight(WEIGHT_BITS'($urandom_range(65536, 0)));
      send_random_blocks(60);
      drain(SETTLE_CYCLES);
    end

    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding_blocks == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/pps_pkg.sv
src/pps_front.sv
src/pps_queue.sv
src/pps_back.sv
src/peak_to_peak_amplitude_smoother.sv
dv/p2p_smoothing_checker.sv
dv/testbench.sv
